>>> sv/cdq_pkg.sv
// Shared constants, codes and types for the circular deque.
package cdq_pkg;

    localparam int DEPTH   = 8;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FILL_W  = 4;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int M_DATA_W = ((DATA_W + FILL_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic             push_front;
        logic             push_rear;
        logic             pop_front;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

>>> sv/cdq_cell.sv
// One storage cell of the deque row; shifts with its neighbors on front operations.
module cdq_cell (
    input  logic                         aclk,
    input  cdq_pkg::cell_ctrl_t          ctrl,
    input  logic [cdq_pkg::IDX_W-1:0]    cell_idx,
    input  logic [cdq_pkg::DATA_W-1:0]   push_value,
    input  logic [cdq_pkg::DATA_W-1:0]   left_data,
    input  logic [cdq_pkg::DATA_W-1:0]   right_data,
    output logic [cdq_pkg::DATA_W-1:0]   cell_data,
    output logic [cdq_pkg::DATA_W-1:0]   rear_tap
);

    logic [cdq_pkg::DATA_W-1:0] data_reg;
    logic [cdq_pkg::DATA_W-1:0] data_next;
    logic [cdq_pkg::CNT_W-1:0]  my_pos;
    logic                       is_rear;

    assign my_pos  = cdq_pkg::CNT_W'(cell_idx);
    assign is_rear = (ctrl.count == my_pos + cdq_pkg::CNT_W'(1));

    always_comb begin
        data_next = data_reg;
        if (ctrl.push_front) begin
            data_next = left_data;
        end else if (ctrl.push_rear && (ctrl.count == my_pos)) begin
            data_next = push_value;
        end else if (ctrl.pop_front) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;
    assign rear_tap  = is_rear ? data_reg : '0;

endmodule

>>> sv/circular_deque.sv
// Top level of the circular deque: a row of shifting cells with a registered result stage.
// An accepted transaction's result is registered and shown on the master side next cycle.
// Throughput: one per cycle while results are taken, as the single output register frees.
// The count register and the cell row update in the cycle a transaction is accepted.
// Reset (aresetn low, synchronous) empties the deque and drops any pending result.
// Cell contents are not cleared; only entries below the count are ever read.
module circular_deque (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cdq_pkg::DATA_W-1:0]     s_tdata,   // push_value[31:0]
    input  logic [cdq_pkg::OP_W-1:0]       s_tuser,   // opcode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cdq_pkg::M_DATA_W-1:0]   m_tdata,   // pop_value[31:0], fill_count[35:32]
    output logic [cdq_pkg::STAT_W-1:0]     m_tuser    // status[1:0]
);

    logic                                     accept;
    cdq_pkg::opcode_t                         opcode;
    cdq_pkg::cell_ctrl_t                      ctrl;
    logic                                     full;
    logic                                     empty;
    logic [cdq_pkg::DEPTH-1:0][cdq_pkg::DATA_W-1:0] cell_data;
    logic [cdq_pkg::DEPTH-1:0][cdq_pkg::DATA_W-1:0] rear_tap;
    logic [cdq_pkg::DATA_W-1:0]               rear_value;

    logic [cdq_pkg::CNT_W-1:0]   count_reg;
    logic [cdq_pkg::CNT_W-1:0]   count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [cdq_pkg::DATA_W-1:0]  pop_value_reg;
    logic [cdq_pkg::DATA_W-1:0]  pop_value_next;
    cdq_pkg::status_t            status_reg;
    cdq_pkg::status_t            status_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign opcode   = cdq_pkg::opcode_t'(s_tuser);
    assign full     = (count_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.push_front = accept && (opcode == cdq_pkg::OP_PUSH_FRONT) && !full;
    assign ctrl.push_rear  = accept && (opcode == cdq_pkg::OP_PUSH_REAR) && !full;
    assign ctrl.pop_front  = accept && (opcode == cdq_pkg::OP_POP_FRONT) && !empty;
    assign ctrl.count      = count_reg;

    for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
        logic [cdq_pkg::DATA_W-1:0] left_data;
        logic [cdq_pkg::DATA_W-1:0] right_data;
        if (i == 0) begin : g_first
            assign left_data = s_tdata;
        end else begin : g_left
            assign left_data = cell_data[i-1];
        end
        if (i == cdq_pkg::DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_right
            assign right_data = cell_data[i+1];
        end
        cdq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (cdq_pkg::IDX_W'(i)),
            .push_value (s_tdata),
            .left_data  (left_data),
            .right_data (right_data),
            .cell_data  (cell_data[i]),
            .rear_tap   (rear_tap[i])
        );
    end

    always_comb begin
        rear_value = '0;
        for (int k = 0; k < cdq_pkg::DEPTH; k++) begin
            rear_value = rear_value | rear_tap[k];
        end
    end

    always_comb begin
        count_next     = count_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (accept) begin
            out_valid_next = 1'b1;
            pop_value_next = '0;
            status_next    = cdq_pkg::ST_DONE;
            case (opcode)
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
                    if (full) begin
                        status_next = cdq_pkg::ST_OVERFLOW;
                    end else begin
                        count_next = count_reg + cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end else begin
                        pop_value_next = cell_data[0];
                        count_next     = count_reg - cdq_pkg::CNT_W'(1);
                    end
                end
                cdq_pkg::OP_POP_REAR: begin
                    if (empty) begin
                        status_next = cdq_pkg::ST_UNDERFLOW;
                    end else begin
                        pop_value_next = rear_value;
                        count_next     = count_reg - cdq_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    logic [cdq_pkg::FILL_W-1:0] fill_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            fill_reg <= cdq_pkg::FILL_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cdq_pkg::M_DATA_W'({fill_reg, pop_value_reg});
    assign m_tuser  = status_reg;

endmodule

>>> dv/circular_deque_tb.sv
// Self-checking testbench for the circular deque: predicts each result and checks it in order.
module circular_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1850;

    typedef struct {
        logic [cdq_pkg::DATA_W-1:0] value;
        cdq_pkg::status_t           st;
        logic [cdq_pkg::FILL_W-1:0] fill;
    } deque_result_t;

    class deque_scoreboard;
        logic [cdq_pkg::DATA_W-1:0] ring [cdq_pkg::DEPTH];
        int unsigned front_idx;
        int unsigned rear_idx;
        int unsigned held;
        deque_result_t results_due[$];
        int mismatches;

        function new();
            front_idx = 0;
            rear_idx = 0;
            held = 0;
            mismatches = 0;
        endfunction

        function void note_input(cdq_pkg::opcode_t op, logic [cdq_pkg::DATA_W-1:0] val);
            deque_result_t res;
            res.value = '0;
            res.st = cdq_pkg::ST_DONE;
            case (op)
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
                    if (held >= cdq_pkg::DEPTH) begin
                        res.st = cdq_pkg::ST_OVERFLOW;
                    end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
                        front_idx = (front_idx == 0) ? cdq_pkg::DEPTH - 1 : front_idx - 1;
                        ring[front_idx] = val;
                        held++;
                    end else begin
                        ring[rear_idx] = val;
                        rear_idx = (rear_idx + 1 >= cdq_pkg::DEPTH) ? 0 : rear_idx + 1;
                        held++;
                    end
                end
                default: begin
                    if (held == 0) begin
                        res.st = cdq_pkg::ST_UNDERFLOW;
                    end else if (op == cdq_pkg::OP_POP_FRONT) begin
                        res.value = ring[front_idx];
                        front_idx = (front_idx + 1 >= cdq_pkg::DEPTH) ? 0 : front_idx + 1;
                        held--;
                    end else begin
                        rear_idx = (rear_idx == 0) ? cdq_pkg::DEPTH - 1 : rear_idx - 1;
                        res.value = ring[rear_idx];
                        held--;
                    end
                end
            endcase
            res.fill = held[cdq_pkg::FILL_W-1:0];
            results_due.push_back(res);
        endfunction

        function void check_result(logic [cdq_pkg::DATA_W-1:0] value, cdq_pkg::status_t st,
                                   logic [cdq_pkg::FILL_W-1:0] fill);
            deque_result_t exp_res;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none outstanding: value %h status %0d fill %0d",
                             $realtime, value, st, fill);
                return;
            end
            exp_res = results_due.pop_front();
            if (value !== exp_res.value || st !== exp_res.st || fill !== exp_res.fill) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected value %h status %0d fill %0d, got %h %0d %0d",
                             $realtime, exp_res.value, exp_res.st, exp_res.fill,
                             value, st, fill);
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [cdq_pkg::DATA_W-1:0]   s_tdata;
    logic [cdq_pkg::OP_W-1:0]     s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [cdq_pkg::M_DATA_W-1:0] m_tdata;
    logic [cdq_pkg::STAT_W-1:0]   m_tuser;

    deque_scoreboard sb = new();
    bit sender_burst;
    bit long_hold_req;

    circular_deque u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[cdq_pkg::DATA_W-1:0], cdq_pkg::status_t'(m_tuser),
                                m_tdata[cdq_pkg::DATA_W +: cdq_pkg::FILL_W]);
            if (s_tvalid && s_tready)
                sb.note_input(cdq_pkg::opcode_t'(s_tuser), s_tdata);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(cdq_pkg::opcode_t op, logic [cdq_pkg::DATA_W-1:0] val);
        int gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_op(cdq_pkg::OP_POP_FRONT, $urandom);
        send_op(cdq_pkg::OP_POP_REAR, $urandom);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(cdq_pkg::OP_PUSH_REAR, 32'h8000_0000);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(cdq_pkg::OP_PUSH_REAR, 32'h0000_0000);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
        send_op(cdq_pkg::OP_PUSH_REAR, 32'h5555_5555);
        for (int i = 6; i < cdq_pkg::DEPTH; i++)
            send_op((i % 2 == 0) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR, $urandom);
        send_op(cdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
        send_op(cdq_pkg::OP_PUSH_REAR, 32'h8765_4321);
        for (int i = 0; i < cdq_pkg::DEPTH; i++)
            send_op((i % 3 == 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR, $urandom);
        send_op(cdq_pkg::OP_POP_FRONT, $urandom);
        send_op(cdq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
        send_op(cdq_pkg::OP_POP_FRONT, $urandom);
    endtask

    task automatic run_random();
        int sent;
        int push_pct;
        int run_len;
        cdq_pkg::opcode_t op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            run_len = $urandom_range(20, 80);
            sender_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
                send_op(op, pick_value());
                sent++;
                if (sent == 600)
                    long_hold_req = 1'b1;
            end
        end
        sender_burst = 1'b0;
    endtask

    initial begin
        int hold_left;
        int cycle_cnt;
        bit rx_burst;
        hold_left = 0;
        cycle_cnt = 0;
        rx_burst = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt % 200 == 0)
                rx_burst = ($urandom_range(0, 2) == 0);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 120;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
                hold_left = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = cdq_pkg::OP_PUSH_FRONT;
        sender_burst = 1'b0;
        long_hold_req = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("** circular_deque: PASSED **");
        else
            $display("** circular_deque: FAILED **");
        $finish;
    end

    initial begin
        #3ms;
        $display("** circular_deque: FAILED **");
        $finish;
    end

endmodule
